### design/analyser_response_frame_parser_defines.svh
// Assertion macros shared by the frame parser checker.
`ifndef ANALYSER_RESPONSE_FRAME_PARSER_DEFINES_SVH
`define ANALYSER_RESPONSE_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ARFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ARFP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/arfp_pkg.sv
// Shared types and constants of the analyser response frame parser.
`default_nettype none

package arfp_pkg;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_CODE   = 2'd1;
    localparam logic [7:0] DEVICE_ADDRESS_RST = 8'h01;
    localparam logic [7:0] COMMAND_CODE_RST   = 8'h03;

    // Content lengths that produce a result
    localparam logic [7:0] LEN_BASIC = 8'h06;
    localparam logic [7:0] LEN_EXT   = 8'h1C;

    // Content byte positions of each field
    localparam logic [8:0] EXT_START  = 9'd12;
    localparam logic [8:0] CONC_FIRST = 9'd0;
    localparam logic [8:0] CONC_LAST  = 9'd3;
    localparam logic [8:0] ALRM_FIRST = 9'd4;
    localparam logic [8:0] ALRM_LAST  = 9'd5;
    localparam logic [8:0] MAG_FIRST  = EXT_START;
    localparam logic [8:0] MAG_LAST   = EXT_START + 9'd1;
    localparam logic [8:0] UNIT_FIRST = EXT_START + 9'd2;
    localparam logic [8:0] UNIT_LAST  = EXT_START + 9'd3;
    localparam logic [8:0] LOW_FIRST  = EXT_START + 9'd4;
    localparam logic [8:0] LOW_LAST   = EXT_START + 9'd7;
    localparam logic [8:0] HIGH_FIRST = EXT_START + 9'd8;
    localparam logic [8:0] HIGH_LAST  = EXT_START + 9'd11;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_ADDR = 4'b0001,
        PH_CMD  = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_DATA = 4'b1000
    } t_phase;

    // Capture control from the framer to the field accumulators
    typedef struct packed {
        logic       en;
        logic [8:0] pos;
        logic [7:0] data;
    } t_cap_ctl;

    // Field accumulators as seen by the framer
    typedef struct packed {
        logic [31:0] conc;
        logic [15:0] alarm;
        logic [15:0] mag;
        logic [15:0] unit;
        logic [31:0] low;
        logic [31:0] high;
    } t_fields;

    // One result beat
    typedef struct packed {
        logic signed [31:0] gas_concentration;
        logic        [15:0] alarm_status;
        logic               has_extended;
        logic        [15:0] magnification;
        logic        [15:0] gas_unit;
        logic signed [31:0] low_alarm_value;
        logic signed [31:0] high_alarm_value;
    } t_result;

endpackage

`default_nettype wire

### design/arfp_if.sv
// Stream interfaces of the frame parser: received bytes in, parsed results out.
`default_nettype none

interface arfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface arfp_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] gas_concentration;
    logic        [15:0] alarm_status;
    logic               has_extended;
    logic        [15:0] magnification;
    logic        [15:0] gas_unit;
    logic signed [31:0] low_alarm_value;
    logic signed [31:0] high_alarm_value;

    modport source (
        output valid, input ready,
        output gas_concentration, output alarm_status, output has_extended,
        output magnification, output gas_unit,
        output low_alarm_value, output high_alarm_value
    );
    modport sink (
        input valid, output ready,
        input gas_concentration, input alarm_status, input has_extended,
        input magnification, input gas_unit,
        input low_alarm_value, input high_alarm_value
    );
endinterface

`default_nettype wire

### design/arfp_capture.sv
// Field accumulators: shift content bytes big-endian into the field they belong to.
`default_nettype none

module arfp_capture
    import arfp_pkg::*;
(
    input  logic     i_clk,
    input  t_cap_ctl i_ctl,
    output t_fields  o_fields
);

    t_fields r_fields;

    // Shift the byte into the field that owns this content position
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.pos inside {[CONC_FIRST:CONC_LAST]}) begin
                r_fields.conc <= {r_fields.conc[23:0], i_ctl.data};
            end else if (i_ctl.pos inside {[ALRM_FIRST:ALRM_LAST]}) begin
                r_fields.alarm <= {r_fields.alarm[7:0], i_ctl.data};
            end else if (i_ctl.pos inside {[MAG_FIRST:MAG_LAST]}) begin
                r_fields.mag <= {r_fields.mag[7:0], i_ctl.data};
            end else if (i_ctl.pos inside {[UNIT_FIRST:UNIT_LAST]}) begin
                r_fields.unit <= {r_fields.unit[7:0], i_ctl.data};
            end else if (i_ctl.pos inside {[LOW_FIRST:LOW_LAST]}) begin
                r_fields.low <= {r_fields.low[23:0], i_ctl.data};
            end else if (i_ctl.pos inside {[HIGH_FIRST:HIGH_LAST]}) begin
                r_fields.high <= {r_fields.high[23:0], i_ctl.data};
            end
        end
    end

    assign o_fields = r_fields;

endmodule

`default_nettype wire

### design/analyser_response_frame_parser.sv
// Analyser response frame parser: takes one received byte per beat and hunts
// for the header (device address, then command code), sliding one byte on a
// mismatch. It then reads a length byte L, collects L content bytes and two
// CRC bytes (the CRC is not checked). A 6-byte content gives concentration and
// alarm status; a 28-byte content also gives magnification, unit and the alarm
// limits; other lengths give nothing. The block takes one byte every cycle
// unless stalled; the result is on o_res in the cycle after the last CRC byte
// is accepted, from a single output register. i_rx.ready drops only while the
// parser waits for that last CRC byte of a result-bearing frame and the previous
// result is still waiting and not taken in that cycle; this does not depend on
// i_rx.valid. Header compares use the register values current at each byte.
`default_nettype none

module analyser_response_frame_parser
    import arfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    arfp_rx_if.sink               i_rx,
    arfp_res_if.source            o_res
);

    logic [7:0] r_dev_addr;
    logic [7:0] r_cmd_code;
    t_phase     r_phase,   n_phase;
    logic [8:0] r_pos,     n_pos;
    logic [7:0] r_len,     n_len;
    logic       r_out_vld, n_out_vld;
    t_result    r_res,     n_res;

    logic       rx_acc;
    logic       last_beat;
    logic       len_ok;
    logic       produce;
    t_cap_ctl   cap_ctl;
    t_fields    fields;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEVICE_ADDRESS_RST;
            r_cmd_code <= COMMAND_CODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEVICE_ADDRESS: r_dev_addr <= i_cfg_wdata;
                CFG_COMMAND_CODE:   r_cmd_code <= i_cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Frame end detection, known from state alone
    assign last_beat = (r_phase == PH_DATA) && (r_pos >= ({1'b0, r_len} + 9'd1));
    assign len_ok    = (r_len == LEN_BASIC) || (r_len == LEN_EXT);
    assign produce   = last_beat && len_ok;

    // Stall only a result-bearing byte while an earlier result waits untaken
    assign i_rx.ready = !(produce && r_out_vld && !o_res.ready);
    assign rx_acc     = i_rx.valid && i_rx.ready;

    // Feed content bytes to the accumulators
    always_comb begin
        cap_ctl.en   = rx_acc && (r_phase == PH_DATA) && (r_pos < {1'b0, r_len});
        cap_ctl.pos  = r_pos;
        cap_ctl.data = i_rx.rx_byte;
    end

    arfp_capture u_capture (
        .i_clk    (i_clk),
        .i_ctl    (cap_ctl),
        .o_fields (fields)
    );

    // Frame phase sequencing
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_len   = r_len;
        if (rx_acc) begin
            case (r_phase)
                PH_ADDR: begin
                    if (i_rx.rx_byte == r_dev_addr) begin
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    if (i_rx.rx_byte == r_cmd_code) begin
                        n_phase = PH_LEN;
                    end else if (i_rx.rx_byte == r_dev_addr) begin
                        n_phase = PH_CMD;
                    end else begin
                        n_phase = PH_ADDR;
                    end
                end
                PH_LEN: begin
                    n_len   = i_rx.rx_byte;
                    n_pos   = '0;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    if (last_beat) begin
                        n_phase = PH_ADDR;
                        n_pos   = '0;
                    end else begin
                        n_pos = r_pos + 9'd1;
                    end
                end
                default: begin
                    n_phase = PH_ADDR;
                end
            endcase
        end
    end

    // Build the result and hold it until taken
    always_comb begin
        n_out_vld = r_out_vld && !o_res.ready;
        n_res     = r_res;
        if (rx_acc && produce) begin
            n_out_vld                = 1'b1;
            n_res.gas_concentration  = fields.conc;
            n_res.alarm_status       = fields.alarm;
            n_res.has_extended       = (r_len == LEN_EXT);
            n_res.magnification      = (r_len == LEN_EXT) ? fields.mag  : '0;
            n_res.gas_unit           = (r_len == LEN_EXT) ? fields.unit : '0;
            n_res.low_alarm_value    = (r_len == LEN_EXT) ? fields.low  : '0;
            n_res.high_alarm_value   = (r_len == LEN_EXT) ? fields.high : '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ADDR;
            r_pos     <= '0;
            r_len     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_out_vld <= n_out_vld;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res.valid             = r_out_vld;
    assign o_res.gas_concentration = r_res.gas_concentration;
    assign o_res.alarm_status      = r_res.alarm_status;
    assign o_res.has_extended      = r_res.has_extended;
    assign o_res.magnification     = r_res.magnification;
    assign o_res.gas_unit          = r_res.gas_unit;
    assign o_res.low_alarm_value   = r_res.low_alarm_value;
    assign o_res.high_alarm_value  = r_res.high_alarm_value;

endmodule

`default_nettype wire

### design/arfp_checker.sv
// Port-level checks of the frame parser, bound to the top level.
`default_nettype none
`include "analyser_response_frame_parser_defines.svh"

module arfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rx_valid,
    input logic        i_rx_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [31:0] i_gas_concentration,
    input logic [15:0] i_alarm_status,
    input logic        i_has_extended,
    input logic [15:0] i_magnification,
    input logic [15:0] i_gas_unit,
    input logic [31:0] i_low_alarm_value,
    input logic [31:0] i_high_alarm_value
);

    // A waiting result beat holds concentration, alarm status, extended flag and low limit
    `ARFP_ASSERT_NXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_gas_concentration) && $stable(i_alarm_status) && $stable(i_has_extended) && $stable(i_low_alarm_value), "result beat changed while stalled")

    // Basic frames carry zero extended fields
    `ARFP_ASSERT_NOW(a_basic_zero, i_res_valid && !i_has_extended, (i_magnification == 16'd0) && (i_gas_unit == 16'd0) && (i_low_alarm_value == 32'd0) && (i_high_alarm_value == 32'd0), "extended field nonzero on basic frame")

    // Input stalls only behind a waiting result
    `ARFP_ASSERT_NOW(a_stall_cause, !i_rx_ready, i_res_valid && !i_res_ready, "input stalled with output free")

    // A fresh result needs a byte accepted in the cycle before
    `ARFP_ASSERT_NXT(a_res_source, i_res_ready || !i_res_valid, !i_res_valid || $past(i_rx_valid && i_rx_ready), "result appeared without an input beat")

endmodule

bind analyser_response_frame_parser arfp_checker u_arfp_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_rx_valid          (i_rx.valid),
    .i_rx_ready          (i_rx.ready),
    .i_res_valid         (o_res.valid),
    .i_res_ready         (o_res.ready),
    .i_gas_concentration (o_res.gas_concentration),
    .i_alarm_status      (o_res.alarm_status),
    .i_has_extended      (o_res.has_extended),
    .i_magnification     (o_res.magnification),
    .i_gas_unit          (o_res.gas_unit),
    .i_low_alarm_value   (o_res.low_alarm_value),
    .i_high_alarm_value  (o_res.high_alarm_value)
);

`default_nettype wire

### tb/tb_analyser_response_frame_parser.sv
// Self-checking testbench of the frame parser: byte stream in, parsed results out.
`default_nettype none

module tb_analyser_response_frame_parser;
    import arfp_pkg::*;

    typedef logic [7:0] t_byte_q [$];

    localparam int CLK_HALF      = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int PHASES        = 6;
    localparam int IDLE_PCT      = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    arfp_rx_if  rx_ch ();
    arfp_res_if res_ch ();

    analyser_response_frame_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_ch),
        .o_res       (res_ch)
    );

    // Parser mirror: configuration, phase, position and field accumulators
    logic [7:0]  hdr_addr;
    logic [7:0]  hdr_cmd;
    t_phase      parse_phase;
    logic [8:0]  body_pos;
    logic [7:0]  body_len;
    t_fields     field_acc;

    t_result     pending_results [$];
    int          fail_count;
    int          frame_items;
    logic        tx_idle_on;
    logic        rx_idle_on;
    logic        hold_on;
    event        hold_go;

    always #CLK_HALF i_clk = ~i_clk;

    // Shift one content byte into the field it belongs to
    function automatic void capture_byte(input logic [8:0] pos, input logic [7:0] b);
        if (pos <= CONC_LAST)
            field_acc.conc = {field_acc.conc[23:0], b};
        else if (pos <= ALRM_LAST)
            field_acc.alarm = {field_acc.alarm[7:0], b};
        else if (pos >= MAG_FIRST && pos <= MAG_LAST)
            field_acc.mag = {field_acc.mag[7:0], b};
        else if (pos >= UNIT_FIRST && pos <= UNIT_LAST)
            field_acc.unit = {field_acc.unit[7:0], b};
        else if (pos >= LOW_FIRST && pos <= LOW_LAST)
            field_acc.low = {field_acc.low[23:0], b};
        else if (pos >= HIGH_FIRST && pos <= HIGH_LAST)
            field_acc.high = {field_acc.high[23:0], b};
    endfunction

    // Advance the parser mirror by one accepted byte; queue the result it yields
    function automatic void parse_byte(input logic [7:0] b);
        t_result r;
        logic    ext;
        case (parse_phase)
            PH_ADDR: begin
                if (b == hdr_addr) parse_phase = PH_CMD;
            end
            PH_CMD: begin
                if (b == hdr_cmd)       parse_phase = PH_LEN;
                else if (b == hdr_addr) parse_phase = PH_CMD;
                else                    parse_phase = PH_ADDR;
            end
            PH_LEN: begin
                body_len    = b;
                body_pos    = '0;
                parse_phase = PH_DATA;
            end
            default: begin
                if (int'(body_pos) < int'(body_len)) capture_byte(body_pos, b);
                if (int'(body_pos) >= int'(body_len) + 1) begin
                    ext = (body_len == LEN_EXT);
                    if (body_len == LEN_BASIC || ext) begin
                        r.gas_concentration = field_acc.conc;
                        r.alarm_status      = field_acc.alarm;
                        r.has_extended      = ext;
                        r.magnification     = ext ? field_acc.mag  : 16'h0;
                        r.gas_unit          = ext ? field_acc.unit : 16'h0;
                        r.low_alarm_value   = ext ? field_acc.low  : 32'h0;
                        r.high_alarm_value  = ext ? field_acc.high : 32'h0;
                        pending_results.push_back(r);
                    end
                    parse_phase = PH_ADDR;
                    body_pos    = '0;
                end else begin
                    body_pos = body_pos + 9'd1;
                end
            end
        endcase
    endfunction

    function automatic t_byte_q rand_body(input int n);
        t_byte_q q;
        for (int k = 0; k < n; k++) q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    function automatic t_byte_q fill_body(input int n, input logic [7:0] v);
        t_byte_q q;
        for (int k = 0; k < n; k++) q.push_back(v);
        return q;
    endfunction

    // Offer one byte, with a random gap first, and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        parse_byte(b);
    endtask

    task automatic send_bytes(input t_byte_q q);
        foreach (q[k]) send_byte(q[k]);
    endtask

    // Header, length, content and two unchecked CRC bytes
    task automatic send_frame(input logic [7:0] a, input logic [7:0] c, input t_byte_q body);
        logic [7:0] len_b;
        len_b = 8'(body.size());
        send_byte(a);
        send_byte(c);
        send_byte(len_b);
        send_bytes(body);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        frame_items += body.size() + 5;
    endtask

    // Drop valid, drain every outstanding result, let the output register settle
    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        if (idx == CFG_DEVICE_ADDRESS)   hdr_addr = v;
        else if (idx == CFG_COMMAND_CODE) hdr_cmd = v;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_header(input logic [7:0] a, input logic [7:0] c);
        write_reg(CFG_DEVICE_ADDRESS, a);
        write_reg(CFG_COMMAND_CODE, c);
    endtask

    // Basic frames with field extremes under the reset header
    task automatic test_basic_frame();
        send_frame(hdr_addr, hdr_cmd, '{8'h80, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF});
        send_frame(hdr_addr, hdr_cmd, '{8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00});
        send_frame(hdr_addr, hdr_cmd, fill_body(int'(LEN_BASIC), 8'hFF));
        send_frame(hdr_addr, hdr_cmd, fill_body(int'(LEN_BASIC), 8'h00));
    endtask

    // Extended frames: extended fields at extremes, then all zero, then random content
    task automatic test_extended_frame();
        t_byte_q body;
        body = fill_body(int'(LEN_EXT), 8'hA5);
        for (int k = 0; k < 4; k++) body[k] = 8'hFF;
        body[MAG_FIRST] = 8'h00;
        body[MAG_LAST]  = 8'h00;
        body[UNIT_FIRST] = 8'hFF;
        body[UNIT_LAST]  = 8'hFF;
        body[LOW_FIRST] = 8'h80;
        for (int k = LOW_FIRST + 1; k <= LOW_LAST; k++) body[k] = 8'h00;
        body[HIGH_FIRST] = 8'h7F;
        for (int k = HIGH_FIRST + 1; k <= HIGH_LAST; k++) body[k] = 8'hFF;
        send_frame(hdr_addr, hdr_cmd, body);
        send_frame(hdr_addr, hdr_cmd, fill_body(int'(LEN_EXT), 8'h00));
        send_frame(hdr_addr, hdr_cmd, rand_body(int'(LEN_EXT)));
    endtask

    // Header hunting: repeated address, mismatching command, stray bytes
    task automatic test_header_slide();
        send_byte(hdr_addr);
        send_frame(hdr_addr, hdr_cmd, rand_body(int'(LEN_BASIC)));
        send_bytes('{hdr_addr, 8'h55});
        send_frame(hdr_addr, hdr_cmd, rand_body(int'(LEN_BASIC)));
        send_bytes('{hdr_cmd, 8'hFF, 8'h00});
        send_frame(hdr_addr, hdr_cmd, rand_body(int'(LEN_BASIC)));
    endtask

    // Lengths that give no result are consumed whole; parser resyncs after
    task automatic test_ignored_lengths();
        send_frame(hdr_addr, hdr_cmd, rand_body(0));
        send_frame(hdr_addr, hdr_cmd, rand_body(5));
        send_frame(hdr_addr, hdr_cmd, rand_body(7));
        send_frame(hdr_addr, hdr_cmd, rand_body(LEN_EXT - 1));
        send_frame(hdr_addr, hdr_cmd, rand_body(LEN_EXT + 1));
        send_frame(hdr_addr, hdr_cmd, rand_body(255));
        send_frame(hdr_addr, hdr_cmd, rand_body(int'(LEN_BASIC)));
    endtask

    // Register extremes, ignored spare indexes, change while past the header
    task automatic test_config_registers();
        t_byte_q body;
        wait_idle();
        set_header(8'hFF, 8'hFF);
        send_frame(hdr_addr, hdr_cmd, rand_body(int'(LEN_BASIC)));
        wait_idle();
        set_header(8'h00, 8'h00);
        write_reg(CFG_SPARE_A, 8'h77);
        write_reg(CFG_SPARE_B, 8'hEE);
        send_frame(hdr_addr, hdr_cmd, rand_body(int'(LEN_EXT)));
        // hold mid-frame, retarget the header, then finish the old frame
        body = rand_body(int'(LEN_BASIC));
        send_bytes('{hdr_addr, hdr_cmd, LEN_BASIC, body[0], body[1], body[2]});
        wait_idle();
        set_header(8'h5A, 8'h10);
        send_bytes('{body[3], body[4], body[5], 8'h12, 8'h34});
        send_frame(hdr_addr, hdr_cmd, rand_body(int'(LEN_BASIC)));
        wait_idle();
        set_header(DEVICE_ADDRESS_RST, COMMAND_CODE_RST);
    endtask

    // Receiver holds off while frames keep coming, then a full drain pause
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        -> hold_go;
        for (int k = 0; k < 6; k++)
            send_frame(hdr_addr, hdr_cmd, rand_body(int'((k % 2) ? LEN_EXT : LEN_BASIC)));
        wait_idle();
        tx_idle_on = 1'b1;
    endtask

    // Mostly well-formed frames, some broken ones and noise, across header settings
    task automatic test_random_traffic();
        int r;
        int lim;
        logic [7:0] a;
        logic [7:0] c;
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0:       begin a = DEVICE_ADDRESS_RST; c = COMMAND_CODE_RST; end
                1:       begin a = 8'h00; c = 8'h00; end
                2:       begin a = 8'hFF; c = 8'hFF; end
                3:       begin a = 8'hFF; c = 8'h00; end
                default: begin a = 8'($urandom_range(0, 255)); c = 8'($urandom_range(0, 255)); end
            endcase
            set_header(a, c);
            // one phase runs with no idling on either side
            tx_idle_on = (p != 2);
            rx_idle_on = (p != 2);
            lim = frame_items + RANDOM_ITEMS / PHASES;
            while (frame_items < lim) begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    send_frame(hdr_addr, hdr_cmd, rand_body(int'(LEN_BASIC)));
                else if (r < 70)
                    send_frame(hdr_addr, hdr_cmd, rand_body(int'(LEN_EXT)));
                else if (r < 78)
                    send_frame(hdr_addr, hdr_cmd, rand_body($urandom_range(0, 40)));
                else if (r < 80)
                    send_frame(hdr_addr, hdr_cmd, rand_body($urandom_range(0, 255)));
                else if (r < 87) begin
                    send_bytes('{hdr_addr, 8'($urandom_range(0, 255))});
                    send_frame(hdr_addr, hdr_cmd, rand_body(int'(LEN_BASIC)));
                end else if (r < 93) begin
                    send_byte(hdr_addr);
                    send_frame(hdr_addr, hdr_cmd, rand_body(int'(LEN_EXT)));
                end else
                    send_bytes(rand_body($urandom_range(1, 4)));
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Result-side ready: random stalls, or a counted hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_on)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= !rx_idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always begin
        @(hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare each result beat with the oldest expected one
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual conc %h alarm %h",
                         $time, res_ch.gas_concentration, res_ch.alarm_status);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("gas_concentration", want.gas_concentration,
                            res_ch.gas_concentration);
                check_field("alarm_status", 32'(want.alarm_status),
                            32'(res_ch.alarm_status));
                check_field("has_extended", 32'(want.has_extended),
                            32'(res_ch.has_extended));
                check_field("magnification", 32'(want.magnification),
                            32'(res_ch.magnification));
                check_field("gas_unit", 32'(want.gas_unit), 32'(res_ch.gas_unit));
                check_field("low_alarm_value", want.low_alarm_value, res_ch.low_alarm_value);
                check_field("high_alarm_value", want.high_alarm_value,
                            res_ch.high_alarm_value);
            end
        end
    end

    initial begin
        #(64'd4800000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;
        hold_on       = 1'b0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        fail_count    = 0;
        frame_items   = 0;
        hdr_addr      = DEVICE_ADDRESS_RST;
        hdr_cmd       = COMMAND_CODE_RST;
        parse_phase   = PH_ADDR;
        body_pos      = '0;
        body_len      = '0;
        field_acc     = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_frame();
        test_extended_frame();
        test_header_slide();
        test_ignored_lengths();
        test_config_registers();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+design
design/arfp_pkg.sv
design/arfp_if.sv
design/arfp_capture.sv
design/analyser_response_frame_parser.sv
design/arfp_checker.sv
tb/tb_analyser_response_frame_parser.sv
